>>> sv/xds_pkg.sv
package xds_pkg;

  localparam int Capacity  = 64;
  localparam int FrontierK = 20;
  localparam int IdxW      = 6;
  localparam int CntW      = 7;

  localparam logic [2:0] StUnverified = 3'd0;
  localparam logic [2:0] StAuth       = 3'd1;
  localparam logic [2:0] StFlight     = 3'd3;
  localparam logic [2:0] StUnreach    = 3'd5;
  localparam logic [2:0] StFailed     = 3'd6;

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpSet    = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;
  localparam logic [1:0] OpNone   = 2'd3;

  localparam logic [2:0] RsInserted = 3'd0;
  localparam logic [2:0] RsDup      = 3'd1;
  localparam logic [2:0] RsZero     = 3'd2;
  localparam logic [2:0] RsFull     = 3'd3;
  localparam logic [2:0] RsSet      = 3'd4;
  localparam logic [2:0] RsRead     = 3'd5;
  localparam logic [2:0] RsBad      = 3'd6;

  localparam logic [1:0] CfgW0 = 2'd0;
  localparam logic [1:0] CfgW1 = 2'd1;
  localparam logic [1:0] CfgW2 = 2'd2;
  localparam logic [1:0] CfgW3 = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] node_w0;
    logic [63:0] node_w1;
    logic [63:0] node_w2;
    logic [63:0] node_w3;
    logic [2:0]  cand_state;
    logic [63:0] peer_ref;
    logic [5:0]  slot;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  position;
    logic [6:0]  entry_count;
    logic [6:0]  frontier_size;
    logic        in_frontier;
    logic [63:0] out_w0;
    logic [63:0] out_w1;
    logic [63:0] out_w2;
    logic [63:0] out_w3;
    logic [2:0]  out_state;
    logic [63:0] out_peer;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_W, S_FIND_END, S_FIND_W, S_EVICT, S_SHIFT_RD, S_SHIFT_WR,
    S_WRITE, S_FRONT, S_FRONT_W, S_OUT_RD, S_OUT_W, S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic            load;       // capture input word
    logic            clr_idx;    // idx = 0
    logic            set_idx_end;// idx = capacity-1 (evict search from top)
    logic            set_idx_at; // idx = fill count (shift start)
    logic            inc_idx;
    logic            dec_idx;
    logic            rd_idx;     // read memory at idx
    logic            rd_idx_m1;  // read memory at idx-1
    logic            eval_scan;  // evaluate scan compare on read data
    logic            wr_shift;   // write held data at idx
    logic            wr_new;     // write new entry at at_r
    logic            wr_dup;     // update duplicate
    logic            wr_state;   // set state op
    logic            eval_front; // frontier accumulate
    logic            rd_pos;     // read memory at pos
    logic            fin;        // build result
    logic [2:0]      status;
  } xds_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] opcode;
    logic       zero_id;
    logic       slot_bad;
    logic       idx_last;    // idx+1 >= fill count
    logic       found_dup;
    logic       found_at;
    logic       full;
    logic       end_found;   // entry held in read data is not in flight
    logic       shift_done;  // idx == at
  } xds_sts_t;

endpackage

>>> sv/xds_datapath.sv
module xds_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  xds_pkg::xds_cmd_t   cmd,
  output xds_pkg::xds_sts_t   sts,
  input  xds_pkg::in_word_t   in_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_sel,
  input  logic [63:0]         cfg_data,
  output xds_pkg::out_word_t  res_word
);

  localparam int EW = 256 + 3 + 64;

  // entry memory: id, state, peer
  logic [EW-1:0] mem [xds_pkg::Capacity];
  logic [EW-1:0] rd_r;

  logic [255:0] tgt_r;
  xds_pkg::in_word_t req_r;
  logic [6:0] fill_r, fill_nxt;
  logic [6:0] idx_r, idx_nxt;
  logic [5:0] at_r, pos_r;
  logic       at_found_r, dup_r;
  logic [6:0] act_r, fsz_r;
  logic       infr_r;

  logic [255:0] nid;
  logic [255:0] eid;
  logic [2:0]   est;
  logic [5:0]   idx6;
  logic [5:0]   rd_addr;
  logic         do_rd;
  logic         wr_en;
  logic [5:0]   wr_addr;
  logic [EW-1:0] wr_data;
  logic         closer, same, term;
  logic         scan_ok, front_ok;

  assign nid  = {req_r.node_w0, req_r.node_w1, req_r.node_w2, req_r.node_w3};
  assign eid  = rd_r[EW-1 -: 256];
  assign est  = rd_r[66:64];
  assign idx6 = idx_r[5:0];
  assign same = (nid == eid);
  // equal distance only on equal id
  assign closer = ((nid ^ tgt_r) < (eid ^ tgt_r));
  assign term = (est == xds_pkg::StUnreach) || (est == xds_pkg::StFailed);
  // only entries below the fill count hold live data
  assign scan_ok  = cmd.eval_scan && (idx_r < fill_r);
  assign front_ok = cmd.eval_front && (idx_r < fill_r);

  // target registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        xds_pkg::CfgW0: tgt_r[255:192] <= cfg_data;
        xds_pkg::CfgW1: tgt_r[191:128] <= cfg_data;
        xds_pkg::CfgW2: tgt_r[127:64]  <= cfg_data;
        xds_pkg::CfgW3: tgt_r[63:0]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // memory read/write address selection
  always_comb begin
    do_rd   = cmd.rd_idx | cmd.rd_idx_m1 | cmd.rd_pos;
    rd_addr = cmd.rd_pos ? pos_r : (cmd.rd_idx_m1 ? idx6 - 6'd1 : idx6);
    wr_en   = 1'b0;
    wr_addr = idx6;
    wr_data = rd_r;
    if (cmd.wr_shift) begin
      wr_en = 1'b1;
    end else if (cmd.wr_new) begin
      wr_en   = 1'b1;
      wr_addr = at_r;
      wr_data = {nid, req_r.cand_state, req_r.peer_ref};
    end else if (cmd.wr_dup) begin
      wr_en   = 1'b1;
      wr_addr = pos_r;
      wr_data = rd_r;
      if (req_r.cand_state == xds_pkg::StAuth &&
          (est == xds_pkg::StUnverified || term))
        wr_data[66:64] = xds_pkg::StAuth;
      if (req_r.peer_ref != 64'd0) wr_data[63:0] = req_r.peer_ref;
    end else if (cmd.wr_state) begin
      wr_en   = 1'b1;
      wr_addr = pos_r;
      wr_data = rd_r;
      wr_data[66:64] = req_r.cand_state;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (do_rd) rd_r <= mem[rd_addr];
  end

  // index counter
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.clr_idx)          idx_nxt = '0;
    else if (cmd.set_idx_end) idx_nxt = 7'(xds_pkg::Capacity - 1);
    else if (cmd.set_idx_at)  idx_nxt = fill_r;
    else if (cmd.inc_idx)     idx_nxt = idx_r + 7'd1;
    else if (cmd.dec_idx)     idx_nxt = idx_r - 7'd1;
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.wr_new && fill_r != 7'(xds_pkg::Capacity)) fill_nxt = fill_r + 7'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      idx_r       <= '0;
      at_found_r  <= 1'b0;
      dup_r       <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      idx_r  <= idx_nxt;
      if (cmd.load) begin
        at_found_r  <= 1'b0;
        dup_r       <= 1'b0;
      end
      // scan: duplicate and first farther entry
      if (scan_ok) begin
        if (same) dup_r <= 1'b1;
        else if (closer && !at_found_r) at_found_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_word;
      pos_r <= in_word.slot;
      at_r  <= fill_r[5:0];
    end
    if (scan_ok) begin
      if (same) pos_r <= idx6;
      else if (closer && !at_found_r) at_r <= idx6;
    end
    if (cmd.wr_new) pos_r <= at_r;
    if (cmd.fin) begin
      res_word.status        <= cmd.status;
      res_word.entry_count   <= fill_r;
      res_word.frontier_size <= fsz_r;
      if (cmd.status == xds_pkg::RsZero || cmd.status == xds_pkg::RsFull ||
          (cmd.status == xds_pkg::RsBad && req_r.opcode == xds_pkg::OpNone))
        res_word.position <= '0;
      else
        res_word.position <= pos_r;
      if (cmd.status == xds_pkg::RsInserted || cmd.status == xds_pkg::RsDup ||
          cmd.status == xds_pkg::RsSet || cmd.status == xds_pkg::RsRead) begin
        res_word.in_frontier <= infr_r;
        res_word.out_w0    <= eid[255:192];
        res_word.out_w1    <= eid[191:128];
        res_word.out_w2    <= eid[127:64];
        res_word.out_w3    <= eid[63:0];
        res_word.out_state <= est;
        res_word.out_peer  <= rd_r[63:0];
      end else begin
        res_word.in_frontier <= 1'b0;
        res_word.out_w0    <= '0;
        res_word.out_w1    <= '0;
        res_word.out_w2    <= '0;
        res_word.out_w3    <= '0;
        res_word.out_state <= '0;
        res_word.out_peer  <= '0;
      end
    end
  end

  // frontier walk: rd_r holds entry idx
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= '0;
      fsz_r  <= '0;
      infr_r <= 1'b0;
    end else if (cmd.load) begin
      act_r  <= '0;
      fsz_r  <= '0;
      infr_r <= 1'b0;
    end else begin
      if (cmd.clr_idx) begin
        act_r <= '0;
        fsz_r <= '0;
      end
      if (front_ok && !term) begin
        act_r <= act_r + 7'd1;
        if (fsz_r != 7'(xds_pkg::FrontierK)) fsz_r <= fsz_r + 7'd1;
        if (idx6 == pos_r) infr_r <= (act_r < 7'(xds_pkg::FrontierK));
      end
    end
  end

  // status to controller
  always_comb begin
    sts.opcode     = req_r.opcode;
    sts.zero_id    = (nid == 256'd0);
    sts.slot_bad   = ({1'b0, req_r.slot} >= fill_r);
    sts.idx_last   = (idx_r + 7'd1 >= fill_r);
    sts.found_dup  = dup_r;
    sts.found_at   = at_found_r;
    sts.full       = (fill_r == 7'(xds_pkg::Capacity));
    sts.end_found  = (est != xds_pkg::StFlight);
    sts.shift_done = (idx6 == at_r);
  end

  // never more entries than capacity
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 7'(xds_pkg::Capacity))
    else $error("fill count over capacity");
  // fill grows by at most one per cycle
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (fill_r == $past(fill_r) || fill_r == $past(fill_r) + 7'd1))
    else $error("fill count jumped");
  // frontier size bounded by K
  a_fsz: assert property (@(posedge clk) disable iff (!rst_n)
    fsz_r <= 7'(xds_pkg::FrontierK))
    else $error("frontier size over K");

endmodule

>>> sv/xds_ctrl.sv
module xds_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  xds_pkg::xds_sts_t sts,
  output xds_pkg::xds_cmd_t cmd
);

  xds_pkg::state_t state_r, state_nxt;
  logic [2:0] st_r, st_nxt;
  logic       ov_r, ov_nxt;
  logic       done_w;

  assign in_stall  = (state_r != xds_pkg::S_IDLE);
  assign out_valid = ov_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    unique case (state_r)
      xds_pkg::S_IDLE:
        if (in_valid) state_nxt = xds_pkg::S_SCAN;
      xds_pkg::S_SCAN: begin
        if (sts.opcode == xds_pkg::OpInsert) begin
          if (sts.zero_id) begin
            st_nxt = xds_pkg::RsZero;
            state_nxt = xds_pkg::S_FRONT;
          end else begin
            state_nxt = xds_pkg::S_SCAN_W;
          end
        end else if (sts.opcode == xds_pkg::OpNone || sts.slot_bad) begin
          st_nxt = xds_pkg::RsBad;
          state_nxt = xds_pkg::S_FRONT;
        end else begin
          st_nxt = (sts.opcode == xds_pkg::OpSet) ? xds_pkg::RsSet : xds_pkg::RsRead;
          state_nxt = xds_pkg::S_OUT_RD;
        end
      end
      // per entry: read, compare, decide
      xds_pkg::S_SCAN_W: state_nxt = xds_pkg::S_FIND_END;
      xds_pkg::S_FIND_END: begin
        // evaluated entry idx; continue or decide
        if (sts.found_dup) begin
          st_nxt = xds_pkg::RsDup;
          state_nxt = xds_pkg::S_OUT_RD;
        end else if (!sts.idx_last) begin
          state_nxt = xds_pkg::S_SCAN;
        end else if (!sts.full) begin
          state_nxt = xds_pkg::S_SHIFT_RD;
        end else if (!sts.found_at) begin
          st_nxt = xds_pkg::RsFull;
          state_nxt = xds_pkg::S_FRONT;
        end else begin
          state_nxt = xds_pkg::S_FIND_W;
        end
      end
      // eviction search from the top down to at: read, then check
      xds_pkg::S_FIND_W: state_nxt = xds_pkg::S_EVICT;
      xds_pkg::S_EVICT: begin
        if (sts.end_found) state_nxt = xds_pkg::S_SHIFT_RD;
        else if (sts.shift_done) begin
          st_nxt = xds_pkg::RsFull;
          state_nxt = xds_pkg::S_FRONT;
        end else state_nxt = xds_pkg::S_FIND_W;
      end
      xds_pkg::S_SHIFT_RD: begin
        if (sts.shift_done) state_nxt = xds_pkg::S_WRITE;
        else state_nxt = xds_pkg::S_SHIFT_WR;
      end
      xds_pkg::S_SHIFT_WR: state_nxt = xds_pkg::S_SHIFT_RD;
      xds_pkg::S_WRITE: begin
        st_nxt = xds_pkg::RsInserted;
        state_nxt = xds_pkg::S_FRONT;
      end
      xds_pkg::S_OUT_RD: state_nxt = xds_pkg::S_OUT_W;
      xds_pkg::S_OUT_W: state_nxt = xds_pkg::S_FRONT;
      xds_pkg::S_FRONT: state_nxt = xds_pkg::S_FRONT_W;
      xds_pkg::S_FRONT_W:
        if (sts.idx_last) state_nxt = xds_pkg::S_DONE;
        else state_nxt = xds_pkg::S_FRONT;
      xds_pkg::S_DONE:
        if (!ov_r || !out_stall) state_nxt = xds_pkg::S_IDLE;
      default: state_nxt = xds_pkg::S_IDLE;
    endcase
  end

  assign done_w = (state_r == xds_pkg::S_DONE) && (!ov_r || !out_stall);

  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (done_w) ov_nxt = 1'b1;
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.status = st_r;
    unique case (state_r)
      xds_pkg::S_IDLE: begin
        cmd.load    = in_valid;
        cmd.clr_idx = in_valid;
      end
      xds_pkg::S_SCAN: cmd.rd_idx = 1'b1;
      xds_pkg::S_SCAN_W: cmd.eval_scan = 1'b1;
      xds_pkg::S_FIND_END: begin
        if (sts.found_dup) cmd.rd_pos = 1'b1;
        else if (!sts.idx_last) begin
          cmd.inc_idx = 1'b1;
        end else if (!sts.full) cmd.set_idx_at = 1'b1;
        else if (sts.found_at) cmd.set_idx_end = 1'b1;
        else cmd.clr_idx = 1'b1;
      end
      xds_pkg::S_FIND_W: cmd.rd_idx = 1'b1;
      xds_pkg::S_EVICT: begin
        // idx stays on the evicted entry when one is found
        if (!sts.end_found) begin
          if (sts.shift_done) cmd.clr_idx = 1'b1;
          else cmd.dec_idx = 1'b1;
        end
      end
      xds_pkg::S_SHIFT_RD: begin
        if (!sts.shift_done) cmd.rd_idx_m1 = 1'b1;
      end
      xds_pkg::S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.dec_idx  = 1'b1;
      end
      xds_pkg::S_WRITE: begin
        cmd.wr_new  = 1'b1;
        cmd.clr_idx = 1'b1;
      end
      xds_pkg::S_OUT_RD: cmd.rd_pos = 1'b1;
      xds_pkg::S_OUT_W: begin
        if (st_r == xds_pkg::RsDup) cmd.wr_dup = 1'b1;
        if (st_r == xds_pkg::RsSet) cmd.wr_state = 1'b1;
        cmd.clr_idx = 1'b1;
      end
      xds_pkg::S_FRONT: cmd.rd_idx = 1'b1;
      xds_pkg::S_FRONT_W: begin
        cmd.eval_front = 1'b1;
        // last entry: fetch the addressed entry for the result
        if (!sts.idx_last) begin
          cmd.inc_idx = 1'b1;
        end else cmd.rd_pos = 1'b1;
      end
      xds_pkg::S_DONE: begin
        cmd.rd_pos = 1'b0;
        cmd.fin    = done_w;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xds_pkg::S_IDLE;
      st_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // accept only in idle
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> state_r == xds_pkg::S_IDLE)
    else $error("accept outside idle");
  // result raised only from done
  a_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r) == xds_pkg::S_DONE)
    else $error("result without done");
  // a pending result is never overwritten
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |-> !cmd.fin)
    else $error("result overwritten");

endmodule

>>> sv/xor_distance_shortlist.sv
// channel | handshake        | payload
// in      | in_valid/in_stall   | xds_pkg::in_word_t
// out     | out_valid/out_stall | xds_pkg::out_word_t
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One word at a time. Insert: a duplicate/place scan over the fill count,
// then the eviction search and the shift, then the frontier walk. Read and
// set-state: a read of the addressed slot, then the frontier walk. The entry
// memory has one read and one write port, so every pass steps through the
// entries one by one.
// Synchronous reset empties the list; out_stall holds the result register.
module xor_distance_shortlist (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  xds_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output xds_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  xds_pkg::xds_cmd_t cmd;
  xds_pkg::xds_sts_t sts;

  assign cfg_ready = 1'b1;

  xds_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  xds_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_word (in_data),
    .cfg_we  (cfg_valid),
    .cfg_sel (cfg_index),
    .cfg_data,
    .res_word(out_data)
  );

endmodule
